>>> src/sidac_pkg.sv
// ----------------------------------------------------------------------------
// sidac_pkg
// shared constants and controller/datapath command and status types
// ----------------------------------------------------------------------------
package sidac_pkg;

  localparam int ValueWidth = 32;
  localparam int CharWidth  = 8;
  localparam int NumDigits  = 10;
  localparam int DigitWidth = 4;
  localparam int IndexWidth = 4;
  localparam int StepWidth  = 5;

  localparam logic [StepWidth-1:0] LastStep   = StepWidth'(ValueWidth - 1);
  localparam logic [CharWidth-1:0] AsciiZero  = 8'h30;
  localparam logic [CharWidth-1:0] AsciiMinus = 8'h2d;

  // commands from the controller
  typedef struct packed {
    logic load;       // capture magnitude and sign, clear bcd
    logic shift;      // one shift-add-3 step
    logic find;       // locate the leading nonzero digit
    logic next;       // move to the next lower digit
    logic emit_sign;  // drive '-' on the output word
  } sidac_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic last_step;
    logic negative;
    logic index_zero;
  } sidac_status_t;

endpackage

>>> src/sidac_datapath.sv
// ----------------------------------------------------------------------------
// sidac_datapath
// magnitude and bcd registers, double-dabble step and character select
// ----------------------------------------------------------------------------
module sidac_datapath
  import sidac_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  sidac_cmd_t                   cmd,
  input  logic signed [ValueWidth-1:0] value,
  output sidac_status_t                status,
  output logic        [CharWidth-1:0]  character,
  output logic                         last
);

  logic [ValueWidth-1:0]                mag;
  logic [NumDigits-1:0][DigitWidth-1:0] bcd;
  logic [NumDigits-1:0][DigitWidth-1:0] bcd_adj;
  logic [StepWidth-1:0]                 step;
  logic [IndexWidth-1:0]                index;
  logic [IndexWidth-1:0]                lead;
  logic                                 negative;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NumDigits; i++) begin
      bcd_adj[i] = (bcd[i] >= DigitWidth'(5)) ? bcd[i] + DigitWidth'(3) : bcd[i];
    end
  end

  // highest nonzero digit, zero when the value is zero
  always_comb begin
    lead = '0;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd[i] != '0) lead = IndexWidth'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.load) begin
      step <= '0;
    end else if (cmd.shift) begin
      step <= step + StepWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      negative <= value[ValueWidth-1];
      mag      <= value[ValueWidth-1] ? $unsigned(-value) : $unsigned(value);
      bcd      <= '0;
    end else if (cmd.shift) begin
      {bcd, mag} <= {bcd_adj[NumDigits-1:0], mag} << 1;
    end
    if (cmd.find) begin
      index <= lead;
    end else if (cmd.next) begin
      index <= index - IndexWidth'(1);
    end
  end

  assign status.last_step  = (step == LastStep);
  assign status.negative   = negative;
  assign status.index_zero = (index == '0);

  assign character = cmd.emit_sign ? AsciiMinus
                                   : AsciiZero + CharWidth'(bcd[index]);
  assign last      = !cmd.emit_sign && (index == '0);

endmodule

>>> src/sidac_ctrl.sv
// ----------------------------------------------------------------------------
// sidac_ctrl
// sequencer: accept, convert, locate leading digit, emit characters
// ----------------------------------------------------------------------------
module sidac_ctrl
  import sidac_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  output logic          m_tvalid,
  input  logic          m_tready,
  input  sidac_status_t status,
  output sidac_cmd_t    cmd
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StConv  = 3'd1;
  localparam logic [2:0] StFind  = 3'd2;
  localparam logic [2:0] StSign  = 3'd3;
  localparam logic [2:0] StDigit = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      StIdle: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = StConv;
        end
      end
      StConv: begin
        cmd.shift = 1'b1;
        if (status.last_step) state_next = StFind;
      end
      StFind: begin
        cmd.find   = 1'b1;
        state_next = status.negative ? StSign : StDigit;
      end
      StSign: begin
        m_tvalid      = 1'b1;
        cmd.emit_sign = 1'b1;
        if (m_tready) state_next = StDigit;
      end
      StDigit: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          if (status.index_zero) begin
            state_next = StIdle;
          end else begin
            cmd.next = 1'b1;
          end
        end
      end
      default: state_next = StIdle;
    endcase
  end

endmodule

>>> src/signed_int_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// converts a signed 32-bit integer into its decimal ascii text
// ----------------------------------------------------------------------------
// usage:
//   slave side takes one word per value: s_tdata is the two's complement
//   integer. master side gives one word per character, most significant
//   first: a leading '-' for negative values, then the digits with no
//   leading zeros ("0" for zero). m_tlast marks the final character.
// sequence:
//   after acceptance the 32 shift-add-3 steps of the bcd conversion run
//   one after another, then the leading digit is located, then the
//   characters are emitted in turn, each advancing only while m_tready is
//   high. a single double-dabble step is shared over all 32 bits.
//   one value is handled at a time; s_tready is high only when idle.
// reset:
//   synchronous, active high; returns to idle with no word pending.
// stalls:
//   while m_tready is low the current character and m_tlast hold steady.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit
  import sidac_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic signed [ValueWidth-1:0] s_tdata,   // [31:0] value
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic        [CharWidth-1:0]  m_tdata,   // [7:0] character
  output logic                         m_tlast
);

  sidac_cmd_t    cmd;
  sidac_status_t status;

  // sequencer for accept, conversion and character emission
  sidac_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // magnitude, bcd digits and output character select
  sidac_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (s_tdata),
    .status    (status),
    .character (m_tdata),
    .last      (m_tlast)
  );

endmodule

>>> tb/signed_int_to_decimal_ascii_unit_test.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_test
// self-checking bench for the signed integer to decimal text converter:
// values are fed on the slave stream, every character word on the master
// stream is checked against text worked out here, with random idling on
// both sides and one long receiver hold-off
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_test
  import sidac_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomItems   = 390;
  localparam int CycleLimit    = 500000;
  localparam int DrainCycles   = 60;    // extra cycles run after the last expected character
  localparam int HoldCycles    = 500;   // long receiver hold-off
  localparam int HoldAfter     = 40;    // values accepted before the hold-off
  localparam int ReportedLimit = 10;

  // one expected character word
  typedef struct {
    logic [CharWidth-1:0] character;
    logic                 last;
  } decimal_char_t;

  logic                         clk      = 1'b0;
  logic                         rst      = 1'b1;
  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic signed [ValueWidth-1:0] s_tdata  = '0;   // [31:0] value
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic        [CharWidth-1:0]  m_tdata;         // [7:0] character
  logic                         m_tlast;

  logic signed [ValueWidth-1:0] pending_values[$];
  decimal_char_t                expected_text[$];

  int item_total     = 1;
  int accepted_count = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;
  int hold_cycles    = 0;
  bit hold_taken     = 1'b0;
  int send_idle_pct;
  int recv_idle_pct;

  signed_int_to_decimal_ascii_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #10 clk = ~clk;

  // idling by phase: receiver-heavy third, sender-heavy swap, then none
  assign send_idle_pct = (accepted_count < item_total / 3)     ? 30 :
                         (accepted_count < 2 * item_total / 3) ? 48 : 0;
  assign recv_idle_pct = (accepted_count < item_total / 3)     ? 48 :
                         (accepted_count < 2 * item_total / 3) ? 30 : 0;

  // decimal text of one value: optional minus, then digits msd first
  function automatic void push_decimal_text(logic signed [ValueWidth-1:0] value);
    logic [ValueWidth-1:0] magnitude;
    logic [CharWidth-1:0]  digit_chars[$];
    decimal_char_t         word;
    magnitude = value[ValueWidth-1] ? (32'd0 - $unsigned(value)) : $unsigned(value);
    do begin
      digit_chars.push_front(AsciiZero + CharWidth'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (value[ValueWidth-1]) begin
      word.character = AsciiMinus;
      word.last      = 1'b0;
      expected_text.push_back(word);
    end
    foreach (digit_chars[i]) begin
      word.character = digit_chars[i];
      word.last      = (i == digit_chars.size() - 1);
      expected_text.push_back(word);
    end
  endfunction

  // driver: holds a word until taken, then offers the next one or idles
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        push_decimal_text(s_tdata);
        accepted_count <= accepted_count + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_values.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tdata  <= pending_values.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long hold-off on the receiver, so the converter backs up its input
  always @(posedge clk) begin
    if (rst) begin
      hold_cycles <= 0;
      hold_taken  <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_taken && accepted_count >= HoldAfter) begin
      hold_cycles <= HoldCycles;
      hold_taken  <= 1'b1;
    end
  end

  // monitor: checks each character word against the oldest expectation
  always @(posedge clk) begin
    decimal_char_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_text.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportedLimit)
            $display("unexpected word: character %h last %b", m_tdata, m_tlast);
        end else begin
          want = expected_text.pop_front();
          if (m_tdata !== want.character || m_tlast !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= ReportedLimit)
              $display("mismatch: character %h last %b, wanted character %h last %b",
                       m_tdata, m_tlast, want.character, want.last);
          end
        end
      end
      m_tready <= (hold_cycles == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("signed_int_to_decimal_ascii_unit_test: done, errors");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int          directed_values[$];
    int unsigned mag;
    int unsigned top;
    int          digits;
    int          value;

    directed_values = {
      0, 1, -1, 9, -9, 10, -10, 99, 100, -100,
      2147483647, 32'h8000_0000, 2147483646, -2147483647,
      999999999, 1000000000, -1000000000, 1234567890, -123456789,
      32'h5555_5555, 32'haaaa_aaaa, 32'hffff_fff6, 7
    };

    foreach (directed_values[i]) pending_values.push_back(directed_values[i]);

    for (int n = 0; n < RandomItems; n++) begin
      case ($urandom_range(3))
        0: value = $urandom();                       // full range, mostly ten digits
        1: begin                                      // a chosen number of digits
          digits = $urandom_range(9, 1);
          top    = 1;
          repeat (digits) top = top * 10;
          mag    = $urandom_range(top - 1, top / 10);
          value  = $urandom_range(1) ? -int'(mag) : int'(mag);
        end
        2: value = $urandom_range(198) - 99;          // short texts, zero included
        default: begin                                // powers of ten and neighbours
          digits = $urandom_range(9);
          top    = 1;
          repeat (digits) top = top * 10;
          mag    = top + $urandom_range(2) - 1;
          value  = $urandom_range(1) ? -int'(mag) : int'(mag);
        end
      endcase
      pending_values.push_back(value);
    end
    item_total = pending_values.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_values.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0 && expected_text.size() == 0) begin
      $display("signed_int_to_decimal_ascii_unit_test: done, clean");
    end else begin
      $display("signed_int_to_decimal_ascii_unit_test: done, errors");
    end
    $finish;
  end

endmodule

>>> signed_int_to_decimal_ascii_unit.f
src/sidac_pkg.sv
src/sidac_datapath.sv
src/sidac_ctrl.sv
src/signed_int_to_decimal_ascii_unit.sv
tb/signed_int_to_decimal_ascii_unit_test.sv
